[design/sst_pkg.sv]
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and constants for the sorted set table.
// ----------------------------------------------------------------------------
package sst_pkg;

	localparam int CMD_W   = 2;
	localparam int VALUE_W = 32;
	localparam int POS_W   = 8;
	localparam int COUNT_W = 9;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT   = 2'd0,
		CMD_ERASE    = 2'd1,
		CMD_CONTAINS = 2'd2,
		CMD_GET      = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t               cmd;
		logic [VALUE_W-1:0] item_value;
		logic [POS_W-1:0]   position;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic [VALUE_W-1:0] read_value;
		logic [COUNT_W-1:0] count;
		logic               is_empty;
	} result_t;

endpackage

[design/sst_ram.sv]
// ----------------------------------------------------------------------------
// sst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[design/sst_engine.sv]
// ----------------------------------------------------------------------------
// sst_engine
// Command sequencer: walks the table one slot per cycle, doing search and the
// in-place shift for insert/erase in a single ascending pass.
// ----------------------------------------------------------------------------
module sst_engine #(
	parameter int CAPACITY   = 256,
	parameter int VALUE_BITS = 32,
	localparam int AW = $clog2(CAPACITY),
	localparam int VW = (VALUE_BITS < sst_pkg::VALUE_W) ? VALUE_BITS : sst_pkg::VALUE_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  sst_pkg::req_t     req,
	output logic              res_valid,
	output sst_pkg::result_t  res,
	input  logic              res_take,
	output logic              ram_we,
	output logic [AW-1:0]     ram_waddr,
	output logic [VW-1:0]     ram_wdata,
	output logic [AW-1:0]     ram_raddr,
	input  logic [VW-1:0]     ram_rdata
);

	localparam int OW = $clog2(CAPACITY + 1);
	localparam int CW = (OW > sst_pkg::POS_W) ? OW : sst_pkg::POS_W;
	localparam int RW = sst_pkg::VALUE_W;
	localparam int NW = sst_pkg::COUNT_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_GET,
		S_DONE
	} state_t;

	state_t        state_q;
	sst_pkg::cmd_t cmd_q;
	logic [VW-1:0] v_q;
	logic [VW-1:0] carry_q;
	logic [VW-1:0] rd_q;
	logic [OW-1:0] k_q;
	logic [OW-1:0] occ_q;
	logic          shifting_q;
	logic          ok_q;

	logic [VW-1:0] v_in;
	logic [CW-1:0] pos_c;
	logic [CW-1:0] occ_c;
	logic [OW-1:0] k_nx;
	logic [OW-1:0] k_prev;
	logic          at_end;
	logic          hit;
	logic          above;

	assign v_in   = req.item_value[VW-1:0];
	assign pos_c  = CW'(req.position);
	assign occ_c  = CW'(occ_q);
	assign k_nx   = k_q + OW'(1);
	assign k_prev = k_q - OW'(1);
	assign at_end = (k_q == occ_q);
	assign hit    = (ram_rdata == v_q);
	assign above  = (ram_rdata > v_q);

	assign req_ready    = (state_q == S_IDLE);
	assign res_valid    = (state_q == S_DONE);
	assign res.ok         = ok_q;
	assign res.read_value = RW'(rd_q);
	assign res.count      = NW'(occ_q);
	assign res.is_empty   = (occ_q == '0);

	// Reads run ahead of the writes (one slot for insert, two for erase), so a
	// write never hits the slot being read.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_q[AW-1:0];
		ram_wdata = v_q;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req.cmd == sst_pkg::CMD_GET) begin
					ram_raddr = pos_c[AW-1:0];
				end
			end
			S_WALK: begin
				ram_raddr = k_nx[AW-1:0];
				unique case (cmd_q)
					sst_pkg::CMD_INSERT: begin
						if (at_end) begin
							ram_we    = 1'b1;
							ram_wdata = shifting_q ? carry_q : v_q;
						end else if (shifting_q) begin
							ram_we    = 1'b1;
							ram_wdata = carry_q;
						end else if (above) begin
							ram_we = 1'b1;
						end
					end
					sst_pkg::CMD_ERASE: begin
						if (!at_end && shifting_q) begin
							ram_we    = 1'b1;
							ram_waddr = k_prev[AW-1:0];
							ram_wdata = ram_rdata;
						end
					end
					sst_pkg::CMD_CONTAINS, sst_pkg::CMD_GET: begin
					end
				endcase
			end
			S_GET, S_DONE: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cmd_q      <= sst_pkg::CMD_INSERT;
			v_q        <= '0;
			carry_q    <= '0;
			rd_q       <= '0;
			k_q        <= '0;
			occ_q      <= '0;
			shifting_q <= 1'b0;
			ok_q       <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q      <= req.cmd;
						v_q        <= v_in;
						k_q        <= '0;
						shifting_q <= 1'b0;
						ok_q       <= 1'b0;
						rd_q       <= '0;
						unique case (req.cmd)
							sst_pkg::CMD_INSERT: begin
								state_q <= (occ_q == OW'(CAPACITY)) ? S_DONE : S_WALK;
							end
							sst_pkg::CMD_GET: begin
								ok_q    <= (pos_c < occ_c);
								state_q <= S_GET;
							end
							sst_pkg::CMD_ERASE, sst_pkg::CMD_CONTAINS: begin
								state_q <= S_WALK;
							end
						endcase
					end
				end
				S_WALK: begin
					unique case (cmd_q)
						sst_pkg::CMD_INSERT: begin
							priority if (at_end) begin
								occ_q   <= occ_q + OW'(1);
								ok_q    <= 1'b1;
								state_q <= S_DONE;
							end else if (shifting_q) begin
								carry_q <= ram_rdata;
								k_q     <= k_nx;
							end else if (hit) begin
								state_q <= S_DONE;
							end else if (above) begin
								carry_q    <= ram_rdata;
								shifting_q <= 1'b1;
								k_q        <= k_nx;
							end else begin
								k_q <= k_nx;
							end
						end
						sst_pkg::CMD_ERASE: begin
							priority if (at_end) begin
								if (shifting_q) begin
									occ_q <= occ_q - OW'(1);
									ok_q  <= 1'b1;
								end
								state_q <= S_DONE;
							end else if (shifting_q) begin
								k_q <= k_nx;
							end else if (hit) begin
								shifting_q <= 1'b1;
								k_q        <= k_nx;
							end else if (above) begin
								state_q <= S_DONE;
							end else begin
								k_q <= k_nx;
							end
						end
						sst_pkg::CMD_CONTAINS: begin
							priority if (at_end) begin
								state_q <= S_DONE;
							end else if (hit) begin
								ok_q    <= 1'b1;
								state_q <= S_DONE;
							end else if (above) begin
								state_q <= S_DONE;
							end else begin
								k_q <= k_nx;
							end
						end
						sst_pkg::CMD_GET: begin
							state_q <= S_DONE;
						end
					endcase
				end
				S_GET: begin
					if (ok_q) begin
						rd_q <= ram_rdata;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
			endcase
		end
	end

endmodule

[design/sorted_set_table.sv]
// ----------------------------------------------------------------------------
// sorted_set_table
// Fixed-capacity set of unique values kept in ascending order in one RAM.
// ----------------------------------------------------------------------------
//  channel  | valid / ready          | payload
//  ---------+------------------------+--------------------------------------
//  request  | req_valid / req_ready  | cmd, item_value, position
//  response | rsp_valid / rsp_ready  | ok, read_value, count, is_empty
//
// Insert, erase and contains walk the table one slot per cycle: up to N + 1 walk
// steps per transaction with N entries stored, between accept and hand-off.
// Get reads its slot directly. The single table RAM read port sets the pace.
// Reset clears the entry count but not the table; table contents need no clearing.
// A response waiting in the output register does not block the next request;
// the engine holds its finished result until that register frees up.
// ----------------------------------------------------------------------------
module sorted_set_table #(
	parameter int CAPACITY   = 256,
	parameter int VALUE_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic [sst_pkg::CMD_W-1:0]     cmd,
	input  logic [sst_pkg::VALUE_W-1:0]   item_value,
	input  logic [sst_pkg::POS_W-1:0]     position,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic                          ok,
	output logic [sst_pkg::VALUE_W-1:0]   read_value,
	output logic [sst_pkg::COUNT_W-1:0]   count,
	output logic                          is_empty
);

	localparam int AW = $clog2(CAPACITY);
	localparam int VW = (VALUE_BITS < sst_pkg::VALUE_W) ? VALUE_BITS : sst_pkg::VALUE_W;

	sst_pkg::req_t    req;
	sst_pkg::result_t res;
	sst_pkg::result_t rsp_q;
	logic             rsp_valid_q;
	logic             res_valid;
	logic             res_take;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [VW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [VW-1:0] ram_rdata;

	assign req.cmd        = sst_pkg::cmd_t'(cmd);
	assign req.item_value = item_value;
	assign req.position   = position;

	assign res_take = res_valid && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (res_take) begin
				rsp_valid_q <= 1'b1;
				rsp_q       <= res;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign ok         = rsp_q.ok;
	assign read_value = rsp_q.read_value;
	assign count      = rsp_q.count;
	assign is_empty   = rsp_q.is_empty;

	sst_engine #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	sst_ram #(
		.WIDTH (VW),
		.DEPTH (CAPACITY)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule
